>>> src/bcpe_pkg.sv
// shared types, widths and the lipo open-circuit-voltage table for the charge estimator
// no dependencies; imported by every module of the block
package bcpe_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 23;
   localparam int COUNT_W  = 8;
   localparam int MV_W     = 16;
   localparam int RES_W    = 4;
   localparam int PCT_W    = 7;

   localparam int PROD1_W = SUM_W + MV_W;
   localparam int PROD2_W = PROD1_W + MV_W;

   // shared divider: widest dividend is the batch sum
   localparam int DIV_W  = SUM_W;
   localparam int DIV_CW = $clog2(DIV_W + 1);

   localparam int TABLE_POINTS = 16;
   localparam int SEG_IW       = $clog2(TABLE_POINTS);
   // widest step of the table is 100 mv
   localparam int SEG_W        = 7;
   localparam int INTERP_W     = SEG_W + PCT_W;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADC_REF_MV          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ADC_RESOLUTION_BITS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVIDER_NUMERATOR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVIDER_DENOMINATOR = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_MV            = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_MV             = 3'd6;

   localparam logic [MV_W-1:0] OCV_MV [TABLE_POINTS] = '{
      16'd3300, 16'd3400, 16'd3500, 16'd3600, 16'd3650, 16'd3700, 16'd3750, 16'd3800,
      16'd3850, 16'd3900, 16'd3950, 16'd4000, 16'd4050, 16'd4100, 16'd4150, 16'd4200
   };

   localparam logic [PCT_W-1:0] OCV_PCT [TABLE_POINTS] = '{
      7'd0,  7'd1,  7'd4,  7'd9,  7'd14, 7'd24, 7'd36, 7'd46,
      7'd55, 7'd64, 7'd72, 7'd78, 7'd84, 7'd90, 7'd95, 7'd100
   };

   localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;
   localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;

   typedef struct packed {
      logic [COUNT_W-1:0] sample_count;
      logic [MV_W-1:0]    adc_ref_mv;
      logic [RES_W-1:0]   adc_resolution_bits;
      logic [MV_W-1:0]    divider_numerator;
      logic [MV_W-1:0]    divider_denominator;
      logic [MV_W-1:0]    empty_mv;
      logic [MV_W-1:0]    full_mv;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCUM,
      OP_AVG_START,
      OP_MUL_REF,
      OP_MUL_DIV,
      OP_SCALE_START,
      OP_CLASSIFY,
      OP_INTERP_START,
      OP_LOAD_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic batch_done;
      logic div_busy;
      logic interp;
      logic out_free;
   } dp_status_type;

endpackage

>>> src/battery_charge_percent_estimator.sv
// Battery charge estimator. Every accepted sample beat on req_ is clamped at zero and added to
// a running sum. The beat that completes a batch of sample_count samples starts the estimate:
// a shared restoring divider, one quotient bit per cycle, forms the average (23 steps), the
// divided battery voltage (16 steps) and the interpolation inside the open-circuit-voltage
// table (14 steps), with one multiply per cycle in between. The interpolation runs only when
// the voltage lies inside the thresholds and the table. req_stall is high from that beat until
// the result is loaded into the output register, and for longer if the previous result is
// still waiting to be taken. Other samples are taken one per cycle while no estimate runs. The
// result waits in an output register, and the next batch is taken in while it waits. battery_mv
// saturates at 65535. Configuration writes on csr_ are always ready and belong in idle time only.
module battery_charge_percent_estimator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [bcpe_pkg::SAMPLE_W-1:0] req_raw_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [bcpe_pkg::PCT_W-1:0]           rsp_charge_percent,
   output logic [bcpe_pkg::MV_W-1:0]            rsp_battery_mv,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bcpe_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bcpe_pkg::MV_W-1:0]            csr_data
);
   import bcpe_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   bcpe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bcpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bcpe_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .cfg                (cfg),
      .req_raw_sample     (req_raw_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_charge_percent (rsp_charge_percent),
      .rsp_battery_mv     (rsp_battery_mv)
   );

endmodule

>>> src/bcpe_csr.sv
// configuration register bank of the charge estimator
// depends on bcpe_pkg for the register indexes and the cfg_type struct
module bcpe_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bcpe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bcpe_pkg::MV_W-1:0]         csr_data,
   output bcpe_pkg::cfg_type                 cfg
);
   import bcpe_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SAMPLE_COUNT:        cfg_in.sample_count        = csr_data[COUNT_W-1:0];
            CSR_ADC_REF_MV:          cfg_in.adc_ref_mv          = csr_data;
            CSR_ADC_RESOLUTION_BITS: cfg_in.adc_resolution_bits = csr_data[RES_W-1:0];
            CSR_DIVIDER_NUMERATOR:   cfg_in.divider_numerator   = csr_data;
            CSR_DIVIDER_DENOMINATOR: cfg_in.divider_denominator = csr_data;
            CSR_EMPTY_MV:            cfg_in.empty_mv            = csr_data;
            CSR_FULL_MV:             cfg_in.full_mv             = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_count        <= 8'd8;
         cfg_ff.adc_ref_mv          <= 16'd3600;
         cfg_ff.adc_resolution_bits <= 4'd12;
         cfg_ff.divider_numerator   <= 16'd2;
         cfg_ff.divider_denominator <= 16'd1;
         cfg_ff.empty_mv            <= 16'd3300;
         cfg_ff.full_mv             <= 16'd4200;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> src/bcpe_div.sv
// shared restoring divider, one quotient bit per cycle, dividend loaded top-aligned
// depends on bcpe_pkg for widths
module bcpe_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bcpe_pkg::DIV_CW-1:0]   steps,
   input  logic [bcpe_pkg::MV_W-1:0]     rem_init,
   input  logic [bcpe_pkg::DIV_W-1:0]    dividend,
   input  logic [bcpe_pkg::MV_W-1:0]     divisor,
   output logic                          busy,
   output logic [bcpe_pkg::DIV_W-1:0]    quotient
);
   import bcpe_pkg::*;

   logic [DIV_CW-1:0] count_ff, count_in;
   logic [MV_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]  q_ff, q_in;
   logic [MV_W-1:0]   div_ff, div_in;
   logic [MV_W:0]     trial;
   logic [MV_W:0]     trial_diff;
   logic              fits;

   assign busy     = (count_ff != '0);
   assign quotient = q_ff;

   always_comb begin
      trial      = {rem_ff, q_ff[DIV_W-1]};
      fits       = (trial >= {1'b0, div_ff});
      trial_diff = trial - {1'b0, div_ff};
      count_in   = count_ff;
      rem_in     = rem_ff;
      q_in       = q_ff;
      div_in     = div_ff;
      if (start) begin
         count_in = steps;
         rem_in   = rem_init;
         q_in     = dividend;
         div_in   = divisor;
      end else if (busy) begin
         count_in = count_ff - 1'b1;
         // remainder stays below the divisor, so the low bits carry it
         rem_in   = fits ? trial_diff[MV_W-1:0] : trial[MV_W-1:0];
         q_in     = {q_ff[DIV_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      div_ff <= div_in;
   end

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      (busy && !start) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("divider step count did not decrement");

endmodule

>>> src/bcpe_datapath.sv
// datapath of the charge estimator: accumulator, multipliers, divider, table lookup, output register
// depends on bcpe_pkg and bcpe_div
module bcpe_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  bcpe_pkg::dp_cmd_type              cmd,
   output bcpe_pkg::dp_status_type           status,
   input  bcpe_pkg::cfg_type                 cfg,
   input  logic signed [bcpe_pkg::SAMPLE_W-1:0] req_raw_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bcpe_pkg::PCT_W-1:0]        rsp_charge_percent,
   output logic [bcpe_pkg::MV_W-1:0]         rsp_battery_mv
);
   import bcpe_pkg::*;

   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] taken_ff, taken_in;
   logic [PROD1_W-1:0] prod1_ff, prod1_in;
   logic [PROD2_W-1:0] prod2_ff, prod2_in;
   logic               sat_ff, sat_in;
   logic [MV_W-1:0]    batt_ff, batt_in;
   logic [PCT_W-1:0]   pct_ff, pct_in;
   logic               interp_ff, interp_in;
   logic [SEG_W-1:0]   diff_ff, diff_in;
   logic [SEG_W-1:0]   dv_ff, dv_in;
   logic [PCT_W-1:0]   dp_ff, dp_in;
   logic [PCT_W-1:0]   lo_p_ff, lo_p_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PCT_W-1:0]   rsp_pct_ff, rsp_pct_in;
   logic [MV_W-1:0]    rsp_mv_ff, rsp_mv_in;

   logic [COUNT_W-1:0]  count_eff;
   logic [MV_W-1:0]     den_eff;
   logic [COUNT_W-1:0]  taken_inc;
   logic [SAMPLE_W-2:0] raw_clamped;
   logic [PROD1_W-1:0]  adc_mv;
   logic [MV_W-1:0]     batt_c;
   logic [SEG_IW-1:0]   seg_hi, seg_lo;
   logic [MV_W-1:0]     seg_diff, seg_span;
   logic [INTERP_W-1:0] interp_num;

   logic               div_start;
   logic [DIV_CW-1:0]  div_steps;
   logic [MV_W-1:0]    div_rem_init;
   logic [DIV_W-1:0]   div_dividend;
   logic [MV_W-1:0]    div_divisor;
   logic               div_busy;
   logic [DIV_W-1:0]   quotient;

   bcpe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .steps    (div_steps),
      .rem_init (div_rem_init),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_comb begin
      count_eff   = (cfg.sample_count == '0) ? COUNT_W'(1) : cfg.sample_count;
      den_eff     = (cfg.divider_denominator == '0) ? MV_W'(1) : cfg.divider_denominator;
      taken_inc   = taken_ff + 1'b1;
      raw_clamped = req_raw_sample[SAMPLE_W-1] ? '0 : req_raw_sample[SAMPLE_W-2:0];
      adc_mv      = prod1_ff >> cfg.adc_resolution_bits;
      batt_c      = sat_ff ? '1 : quotient[MV_W-1:0];
      interp_num  = diff_ff * dp_ff;

      // first table point at or above the voltage closes the segment
      seg_hi = SEG_IW'(TABLE_POINTS - 1);
      for (int k = TABLE_POINTS - 1; k >= 1; k--) begin
         if (batt_c <= OCV_MV[k]) begin
            seg_hi = SEG_IW'(k);
         end
      end
      seg_lo   = seg_hi - 1'b1;
      seg_diff = batt_c - OCV_MV[seg_lo];
      seg_span = OCV_MV[seg_hi] - OCV_MV[seg_lo];
   end

   always_comb begin
      sum_in       = sum_ff;
      taken_in     = taken_ff;
      prod1_in     = prod1_ff;
      prod2_in     = prod2_ff;
      sat_in       = sat_ff;
      batt_in      = batt_ff;
      pct_in       = pct_ff;
      interp_in    = interp_ff;
      diff_in      = diff_ff;
      dv_in        = dv_ff;
      dp_in        = dp_ff;
      lo_p_in      = lo_p_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pct_in   = rsp_pct_ff;
      rsp_mv_in    = rsp_mv_ff;
      div_start    = 1'b0;
      div_steps    = DIV_CW'(SUM_W);
      div_rem_init = '0;
      div_dividend = sum_ff;
      div_divisor  = MV_W'(count_eff);

      case (cmd.op)
         OP_ACCUM: begin
            sum_in   = sum_ff + SUM_W'(raw_clamped);
            taken_in = taken_inc;
         end
         OP_AVG_START: begin
            div_start = 1'b1;
            sum_in    = '0;
            taken_in  = '0;
         end
         OP_MUL_REF: begin
            prod1_in = PROD1_W'(quotient) * PROD1_W'(cfg.adc_ref_mv);
         end
         OP_MUL_DIV: begin
            prod2_in = PROD2_W'(adc_mv) * PROD2_W'(cfg.divider_numerator);
         end
         OP_SCALE_START: begin
            // quotient above 16 bits exactly when the product reaches den * 2^16
            sat_in       = (prod2_ff >= PROD2_W'({den_eff, {MV_W{1'b0}}}));
            div_start    = 1'b1;
            div_steps    = DIV_CW'(MV_W);
            div_rem_init = prod2_ff[2*MV_W-1:MV_W];
            div_dividend = {prod2_ff[MV_W-1:0], {(DIV_W-MV_W){1'b0}}};
            div_divisor  = den_eff;
         end
         OP_CLASSIFY: begin
            batt_in   = batt_c;
            interp_in = 1'b0;
            diff_in   = seg_diff[SEG_W-1:0];
            dv_in     = seg_span[SEG_W-1:0];
            dp_in     = OCV_PCT[seg_hi] - OCV_PCT[seg_lo];
            lo_p_in   = OCV_PCT[seg_lo];
            if (batt_c <= cfg.empty_mv) begin
               pct_in = PCT_EMPTY;
            end else if (batt_c >= cfg.full_mv) begin
               pct_in = PCT_FULL;
            end else if (batt_c <= OCV_MV[0]) begin
               pct_in = PCT_EMPTY;
            end else if (batt_c >= OCV_MV[TABLE_POINTS-1]) begin
               pct_in = PCT_FULL;
            end else begin
               pct_in    = PCT_EMPTY;
               interp_in = 1'b1;
            end
         end
         OP_INTERP_START: begin
            div_start    = 1'b1;
            div_steps    = DIV_CW'(INTERP_W);
            div_dividend = {interp_num, {(DIV_W-INTERP_W){1'b0}}};
            div_divisor  = MV_W'(dv_ff);
         end
         OP_LOAD_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_mv_in    = batt_ff;
            rsp_pct_in   = interp_ff ? lo_p_ff + quotient[PCT_W-1:0] : pct_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         taken_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         taken_ff     <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod1_ff   <= prod1_in;
      prod2_ff   <= prod2_in;
      sat_ff     <= sat_in;
      batt_ff    <= batt_in;
      pct_ff     <= pct_in;
      interp_ff  <= interp_in;
      diff_ff    <= diff_in;
      dv_ff      <= dv_in;
      dp_ff      <= dp_in;
      lo_p_ff    <= lo_p_in;
      rsp_pct_ff <= rsp_pct_in;
      rsp_mv_ff  <= rsp_mv_in;
   end

   assign status.batch_done = (taken_inc >= count_eff);
   assign status.div_busy   = div_busy;
   assign status.interp     = interp_ff;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_charge_percent = rsp_pct_ff;
   assign rsp_battery_mv     = rsp_mv_ff;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LOAD_OUT) |=> rsp_valid_ff)
      else $error("loaded result beat not presented");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pct_ff <= PCT_FULL))
      else $error("charge percent above full");

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

endmodule

>>> src/bcpe_ctrl.sv
// sequencer of the charge estimator: takes sample beats and steps the datapath through a batch
// depends on bcpe_pkg for the command and status structs
module bcpe_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  bcpe_pkg::dp_status_type   status,
   output bcpe_pkg::dp_cmd_type      cmd
);
   import bcpe_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AVG,
      ST_AVG_WAIT,
      ST_MUL_DIV,
      ST_SCALE,
      ST_SCALE_WAIT,
      ST_INTERP,
      ST_INTERP_WAIT,
      ST_OUTPUT
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_ACCUM;
               if (status.batch_done) begin
                  state_in = ST_AVG;
               end
            end
         end
         ST_AVG: begin
            cmd.op   = OP_AVG_START;
            state_in = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (!status.div_busy) begin
               cmd.op   = OP_MUL_REF;
               state_in = ST_MUL_DIV;
            end
         end
         ST_MUL_DIV: begin
            cmd.op   = OP_MUL_DIV;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.op   = OP_SCALE_START;
            state_in = ST_SCALE_WAIT;
         end
         ST_SCALE_WAIT: begin
            if (!status.div_busy) begin
               cmd.op   = OP_CLASSIFY;
               state_in = ST_INTERP;
            end
         end
         ST_INTERP: begin
            if (status.interp) begin
               cmd.op   = OP_INTERP_START;
               state_in = ST_INTERP_WAIT;
            end else begin
               state_in = ST_OUTPUT;
            end
         end
         ST_INTERP_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            // wait for the output register to free up
            if (status.out_free) begin
               cmd.op   = OP_LOAD_OUT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_batch_end: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && status.batch_done) |=> (state_ff == ST_AVG))
      else $error("last sample of a batch did not start the estimate");

endmodule

>>> sim/battery_charge_percent_estimator_test.sv
// self-checking bench for the battery charge estimator: sample beats in, charge estimates out
// holds its own batch-average and lipo table predictor; needs bcpe_pkg and the estimator rtl
`timescale 1ns / 100ps

module battery_charge_percent_estimator_test;
   import bcpe_pkg::*;

   localparam int CLOCK_PERIOD  = 12;
   localparam int ITEM_TARGET   = 950;
   localparam int SETTLE_CYCLES = 100;
   localparam int LIMIT_CYCLES  = 500000;
   localparam int MAX_REPORTS   = 10;
   localparam int IDLE_PERCENT  = 23;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 3'd7;

   localparam int unsigned LIPO_MV [TABLE_POINTS] = '{
      3300, 3400, 3500, 3600, 3650, 3700, 3750, 3800,
      3850, 3900, 3950, 4000, 4050, 4100, 4150, 4200
   };
   localparam int unsigned LIPO_PCT [TABLE_POINTS] = '{
      0, 1, 4, 9, 14, 24, 36, 46, 55, 64, 72, 78, 84, 90, 95, 100
   };

   typedef struct packed {
      logic [PCT_W-1:0] charge_percent;
      logic [MV_W-1:0]  battery_mv;
   } charge_estimate_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_raw_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [PCT_W-1:0]           rsp_charge_percent;
   logic [MV_W-1:0]            rsp_battery_mv;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [MV_W-1:0]            csr_data = '0;

   // predictor copy of the settings and the batch state
   logic [COUNT_W-1:0] cfg_sample_count        = 8'd8;
   logic [MV_W-1:0]    cfg_adc_ref_mv          = 16'd3600;
   logic [RES_W-1:0]   cfg_adc_resolution_bits = 4'd12;
   logic [MV_W-1:0]    cfg_divider_numerator   = 16'd2;
   logic [MV_W-1:0]    cfg_divider_denominator = 16'd1;
   logic [MV_W-1:0]    cfg_empty_mv            = 16'd3300;
   logic [MV_W-1:0]    cfg_full_mv             = 16'd4200;
   logic [SUM_W-1:0]   batch_sum   = '0;
   logic [COUNT_W-1:0] batch_taken = '0;

   logic signed [SAMPLE_W-1:0] samples_pending [$];
   charge_estimate_type        estimates_due [$];
   int  beats_queued = 0;
   int  beats_sent = 0;
   int  estimates_outstanding = 0;
   int  estimates_checked = 0;
   int  mismatches = 0;
   int  settings_applied = 0;
   bit  sample_beat = 1'b0;
   bit  gaps_on = 1'b1;

   battery_charge_percent_estimator DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_raw_sample     (req_raw_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_charge_percent (rsp_charge_percent),
      .rsp_battery_mv     (rsp_battery_mv),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   function automatic logic [PCT_W-1:0] ocv_percent(input logic [MV_W-1:0] mv);
      if (mv <= LIPO_MV[0]) return PCT_EMPTY;
      if (mv >= LIPO_MV[TABLE_POINTS-1]) return PCT_FULL;
      for (int k = 1; k < TABLE_POINTS; k++)
         if (mv <= LIPO_MV[k])
            return PCT_W'(LIPO_PCT[k-1] + (mv - LIPO_MV[k-1]) * (LIPO_PCT[k] - LIPO_PCT[k-1])
                          / (LIPO_MV[k] - LIPO_MV[k-1]));
      return PCT_EMPTY;
   endfunction

   // adds one sample to the batch; returns 1 with the estimate when the batch closes
   function automatic bit accumulate_sample(input logic signed [SAMPLE_W-1:0] raw,
                                            output charge_estimate_type est);
      logic [SUM_W-1:0] addend;
      longint unsigned  count_eff, den_eff, avg, adc_mv, scaled;
      logic [MV_W-1:0]  mv;
      est = '0;
      addend = raw[SAMPLE_W-1] ? '0 : {{(SUM_W-SAMPLE_W){1'b0}}, raw};
      batch_sum = batch_sum + addend;
      batch_taken = batch_taken + 1'b1;
      count_eff = (cfg_sample_count == 0) ? 1 : cfg_sample_count;
      if (batch_taken < count_eff) return 1'b0;
      den_eff = (cfg_divider_denominator == 0) ? 1 : cfg_divider_denominator;
      avg = batch_sum / count_eff;
      adc_mv = (avg * cfg_adc_ref_mv) >> cfg_adc_resolution_bits;
      scaled = adc_mv * cfg_divider_numerator / den_eff;
      mv = (scaled > 65535) ? 16'hFFFF : scaled[MV_W-1:0];
      if (mv <= cfg_empty_mv)
         est.charge_percent = PCT_EMPTY;
      else if (mv >= cfg_full_mv)
         est.charge_percent = PCT_FULL;
      else
         est.charge_percent = ocv_percent(mv);
      est.battery_mv = mv;
      batch_sum = '0;
      batch_taken = '0;
      return 1'b1;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] clip_sample(input longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[SAMPLE_W-1:0];
   endfunction

   // mostly jitter around a voltage target, some plain adc codes, some full-range noise
   function automatic logic signed [SAMPLE_W-1:0] batch_sample(input longint centre);
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 65) return clip_sample(centre + longint'($urandom_range(6)) - 3);
      if (pick < 85)
         return clip_sample(longint'($urandom_range((1 << cfg_adc_resolution_bits) - 1)));
      return SAMPLE_W'($urandom);
   endfunction

   task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
      samples_pending.push_back(s);
      beats_queued++;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index, input logic [MV_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_SAMPLE_COUNT:        cfg_sample_count        = value[COUNT_W-1:0];
         CSR_ADC_REF_MV:          cfg_adc_ref_mv          = value;
         CSR_ADC_RESOLUTION_BITS: cfg_adc_resolution_bits = value[RES_W-1:0];
         CSR_DIVIDER_NUMERATOR:   cfg_divider_numerator   = value;
         CSR_DIVIDER_DENOMINATOR: cfg_divider_denominator = value;
         CSR_EMPTY_MV:            cfg_empty_mv            = value;
         CSR_FULL_MV:             cfg_full_mv             = value;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [MV_W-1:0] count, ref_mv, res_bits, num, den,
                             empty_mv, full_mv);
      write_register(CSR_SAMPLE_COUNT, count);
      write_register(CSR_ADC_REF_MV, ref_mv);
      write_register(CSR_ADC_RESOLUTION_BITS, res_bits);
      write_register(CSR_DIVIDER_NUMERATOR, num);
      write_register(CSR_DIVIDER_DENOMINATOR, den);
      write_register(CSR_EMPTY_MV, empty_mv);
      write_register(CSR_FULL_MV, full_mv);
      // unused index, must be ignored
      write_register(CSR_SPARE_INDEX, MV_W'($urandom));
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // all beats taken and all estimates back, then room for a batch still in the divider
   task automatic wait_idle();
      wait (beats_sent == beats_queued && estimates_outstanding == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // sample driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || sample_beat) begin
         if (samples_pending.size() != 0 && !(gaps_on && $urandom_range(99) < IDLE_PERCENT)) begin
            req_valid      <= 1'b1;
            req_raw_sample <= samples_pending.pop_front();
         end else begin
            req_valid      <= 1'b0;
            req_raw_sample <= SAMPLE_W'($urandom);
         end
      end
   end

   always @(posedge clock) begin : take_samples
      charge_estimate_type est;
      sample_beat = !reset && req_valid && !req_stall;
      if (sample_beat) begin
         beats_sent++;
         if (accumulate_sample(req_raw_sample, est)) begin
            estimates_due.push_back(est);
            estimates_outstanding++;
         end
      end
   end

   always @(negedge clock)
      rsp_stall <= gaps_on && ($urandom_range(99) < IDLE_PERCENT);

   always @(posedge clock) begin : check_estimates
      charge_estimate_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (estimates_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected estimate: %0d %% %0d mV", rsp_charge_percent, rsp_battery_mv);
         end else begin
            want = estimates_due.pop_front();
            estimates_outstanding--;
            estimates_checked++;
            if (rsp_charge_percent !== want.charge_percent || rsp_battery_mv !== want.battery_mv) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("estimate %0d: expected %0d %% %0d mV, got %0d %% %0d mV",
                           estimates_checked, want.charge_percent, want.battery_mv,
                           rsp_charge_percent, rsp_battery_mv);
            end
         end
      end
   end

   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("timeout: %0d of %0d beats taken, %0d estimates outstanding",
               beats_sent, beats_queued, estimates_outstanding);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int          phase, batches, count_eff, target, pick;
      longint      centre, den_eff, num_eff;
      logic [15:0] c_w, ref_w, res_w, num_w, den_w, empty_w, full_w;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: one batch of eight with field extremes and negatives
      push_sample(16'sd0);     push_sample(-16'sd32768); push_sample(16'sd32767);
      push_sample(-16'sd1);    push_sample(16'sd1);      push_sample(16'sd2048);
      push_sample(16'sd4095);  push_sample(16'sd1024);
      wait_idle();

      // one sample per batch, either side of the empty and full thresholds
      set_config(1, 3600, 12, 2, 1, 3300, 4200);
      push_sample(16'sd1878);  push_sample(16'sd1879);  push_sample(16'sd2100);
      push_sample(16'sd2389);  push_sample(16'sd2390);  push_sample(16'sd32767);
      wait_idle();

      // zero count and zero denominator, thresholds wide open so the table ends apply
      set_config(0, 65535, 15, 1, 0, 0, 65535);
      push_sample(16'sd0);     push_sample(16'sd1000);  push_sample(16'sd2200);
      push_sample(16'sd32767);
      wait_idle();

      // saturation, low shift, empty above full; leave a part batch behind
      set_config(3, 1, 3, 65535, 1, 4000, 3500);
      repeat (3) push_sample(16'sd32767);
      repeat (3) push_sample(16'sd0);
      push_sample(16'sd32767); push_sample(-16'sd32768);
      wait_idle();

      phase = 0;
      while (beats_queued < ITEM_TARGET) begin
         gaps_on = !(phase >= 1 && phase <= 3);

         pick = $urandom_range(99);
         c_w = (pick < 10) ? 16'd0 : (pick < 25) ? 16'd1 : 16'($urandom_range(2, 12));
         pick = $urandom_range(99);
         ref_w = (pick < 10) ? 16'd1 : (pick < 20) ? 16'd65535 :
                 (pick < 50) ? 16'd3600 : 16'($urandom_range(1000, 65535));
         pick = $urandom_range(99);
         res_w = (pick < 15) ? 16'($urandom_range(7)) : 16'($urandom_range(8, 15));
         pick = $urandom_range(99);
         num_w = (pick < 10) ? 16'd65535 : (pick < 20) ? 16'd1 : 16'($urandom_range(1, 8));
         pick = $urandom_range(99);
         den_w = (pick < 10) ? 16'd0 : (pick < 20) ? 16'd65535 : 16'($urandom_range(1, 4));
         pick = $urandom_range(99);
         if (pick < 50) begin
            empty_w = 16'd3300;
            full_w  = 16'd4200;
         end else if (pick < 65) begin
            empty_w = 16'd0;
            full_w  = 16'd65535;
         end else if (pick < 75) begin
            empty_w = 16'($urandom_range(3500, 4000));
            full_w  = 16'($urandom_range(3300, empty_w));
         end else if (pick < 85) begin
            empty_w = 16'($urandom_range(3000, 4500));
            full_w  = 16'($urandom_range(3000, 4500));
         end else begin
            empty_w = 16'($urandom);
            full_w  = 16'($urandom);
         end
         // count drops under the part batch left from before
         if (phase == 0) c_w = 16'd1;
         // one long batch at the largest count, driven to saturation
         if (phase == 4) begin
            c_w   = 16'd255;
            ref_w = 16'd65535;
            res_w = 16'd0;
            num_w = 16'd65535;
         end
         c_w   = (16'($urandom) & 16'hFF00) | c_w;
         res_w = (16'($urandom) & 16'hFFF0) | res_w;
         set_config(c_w, ref_w, res_w, num_w, den_w, empty_w, full_w);

         count_eff = (cfg_sample_count == 0) ? 1 : cfg_sample_count;
         batches   = (count_eff > 16) ? 1 : $urandom_range(2, 6);
         den_eff   = (cfg_divider_denominator == 0) ? 1 : cfg_divider_denominator;
         num_eff   = (cfg_divider_numerator == 0) ? 1 : cfg_divider_numerator;
         repeat (batches) begin
            pick = $urandom_range(99);
            if (pick < 15)
               target = int'(cfg_empty_mv) + int'($urandom_range(4)) - 2;
            else if (pick < 30)
               target = int'(cfg_full_mv) + int'($urandom_range(4)) - 2;
            else
               target = $urandom_range(3150, 4350);
            if (target < 0) target = 0;
            // raw code that lands near the target voltage under the current settings
            centre = ((longint'(target) * den_eff) << cfg_adc_resolution_bits)
                     / (longint'(cfg_adc_ref_mv) * num_eff);
            if (phase == 4) centre = 32767;
            repeat (count_eff) push_sample(batch_sample(centre));
         end
         if (count_eff <= 16)
            repeat ($urandom_range(count_eff - 1)) push_sample(batch_sample(centre));
         wait_idle();
         phase++;
      end

      $display("run covered %0d sample beats and %0d charge estimates over %0d register settings",
               beats_sent, estimates_checked, settings_applied);
      $display("%0d mismatching or unexpected estimates", mismatches);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
